FILE: hdl/sbde_pkg.sv
package sbde_pkg;

    localparam int COUPLING_W   = 16;
    localparam int SITE_COUNT_W = 5;
    localparam int SITE_W       = 4;
    localparam int SPIN_W       = 16;
    localparam int ENERGY_W     = 22;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 16;

    localparam logic [COUPLING_W-1:0]   COUPLING_RESET   = 16'd256;
    localparam logic [SITE_COUNT_W-1:0] SITE_COUNT_RESET = 5'd16;

    localparam logic [CFG_INDEX_W-1:0] CFG_COUPLING   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SITE_COUNT = 1'b1;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_EVAL = 1'b1;

    typedef struct packed {
        logic              second_negated;
        logic              second_present;
        logic [SITE_W-1:0] second_partner;
        logic              first_present;
        logic [SITE_W-1:0] first_partner;
    } t_bond_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FINISH
    } t_fsm;

    typedef struct packed {
        logic write_entry;
        logic start;
        logic step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic empty;
    } t_status;

endpackage

FILE: hdl/sbde_datapath.sv
module sbde_datapath
    import sbde_pkg::*;
#(
    parameter int MAX_SITES = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]          i_cfg_data,
    input  logic [SITE_W-1:0]              i_site,
    input  t_bond_entry                    i_entry,
    input  logic [SPIN_W-1:0]              i_spin_state,
    input  t_cmd                           i_cmd,
    output t_status                        o_status,
    output logic signed [ENERGY_W-1:0]     o_energy
);

    localparam int CW = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
    localparam int NW = $clog2(MAX_SITES + 1);

    logic signed [COUPLING_W-1:0]   r_coupling;
    logic [SITE_COUNT_W-1:0]        r_site_count;
    t_bond_entry                    r_table [MAX_SITES];
    logic [SPIN_W-1:0]              r_state;
    logic [CW-1:0]                  r_cnt;
    logic signed [ENERGY_W-1:0]     r_acc;
    logic signed [ENERGY_W-1:0]     r_energy;

    logic [NW-1:0]                  n_limit;
    t_bond_entry                    rd_entry;
    logic                           s0;
    logic                           s1;
    logic                           s2;
    logic signed [ENERGY_W-1:0]     c_ext;
    logic signed [ENERGY_W-1:0]     term1;
    logic signed [ENERGY_W-1:0]     term2;
    logic signed [ENERGY_W-1:0]     n_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coupling   <= COUPLING_RESET;
            r_site_count <= SITE_COUNT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_COUPLING:   r_coupling   <= i_cfg_data[COUPLING_W-1:0];
                CFG_SITE_COUNT: r_site_count <= i_cfg_data[SITE_COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // sites visited, clipped to the table depth
    always_comb begin
        if (int'(r_site_count) > MAX_SITES) begin
            n_limit = NW'(MAX_SITES);
        end else begin
            n_limit = NW'(r_site_count);
        end
    end

    assign o_status.empty = (n_limit == '0);
    assign o_status.last  = ((NW'(r_cnt) + NW'(1)) == n_limit);

    always_ff @(posedge i_clk) begin
        if (i_cmd.write_entry && (int'(i_site) < MAX_SITES)) begin
            r_table[CW'(i_site)] <= i_entry;
        end
    end

    assign rd_entry = r_table[r_cnt];
    assign s0       = 1'(({16'd0, r_state} >> r_cnt));
    assign s1       = r_state[rd_entry.first_partner];
    assign s2       = r_state[rd_entry.second_partner];
    assign c_ext    = ENERGY_W'(r_coupling);

    always_comb begin
        term1 = '0;
        term2 = '0;
        if (rd_entry.first_present) begin
            term1 = (s0 == s1) ? c_ext : -c_ext;
        end
        if (rd_entry.second_present) begin
            term2 = ((s0 == s2) != rd_entry.second_negated) ? c_ext : -c_ext;
        end
        n_acc = r_acc + term1 + term2;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_state <= i_spin_state;
            r_cnt   <= '0;
            r_acc   <= '0;
        end else if (i_cmd.step) begin
            r_cnt   <= r_cnt + CW'(1);
            r_acc   <= n_acc;
        end
        if (i_cmd.load_out) begin
            r_energy <= r_acc;
        end
    end

    assign o_energy = r_energy;

endmodule

FILE: hdl/sbde_controller.sv
module sbde_controller
    import sbde_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_mode,
    output logic    o_stall,
    output logic    o_valid,
    input  logic    i_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_fsm r_fsm;
    t_fsm n_fsm;
    logic r_valid;
    logic accept;
    logic out_free;

    assign accept   = i_valid && !o_stall;
    assign out_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm <= S_IDLE;
        end else begin
            r_fsm <= n_fsm;
        end
    end

    always_comb begin
        n_fsm   = r_fsm;
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_fsm)
            S_IDLE: begin
                o_stall = !i_rst_n;
                if (i_valid && i_rst_n) begin
                    if (i_mode == MODE_EVAL) begin
                        o_cmd.start = 1'b1;
                        n_fsm = i_status.empty ? S_FINISH : S_RUN;
                    end else begin
                        o_cmd.write_entry = 1'b1;
                    end
                end
            end
            S_RUN: begin
                o_cmd.step = 1'b1;
                if (i_status.last) begin
                    n_fsm = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_fsm = S_IDLE;
                end
            end
            default: begin
                n_fsm = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_cmd.load_out) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid = r_valid;

    a_load_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_valid || !i_stall))
        else $error("result register overwritten while held");

    a_eval_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_mode == MODE_EVAL && !i_status.empty) |=> (r_fsm == S_RUN))
        else $error("evaluate transaction did not start the walk");

    a_last_finishes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == S_RUN && i_status.last) |=> (r_fsm == S_FINISH))
        else $error("walk did not end after last site");

    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_cmd.load_out))
        else $error("result valid without a result load");

endmodule

FILE: hdl/spin_bond_diagonal_energy.sv
// Diagonal energy of a spin-1/2 basis state. A load transaction (mode 0) writes
// one site's bond entry and gives no result; loads to a site at or beyond
// MAX_SITES are dropped. An evaluate transaction (mode 1) walks the bond table
// one site per cycle and gives one energy in units of 2^-10: after acceptance
// the input is stalled through the walk over n = min(site_count, MAX_SITES)
// entries and a final step that moves the sum into the output register, which
// waits while that register is still held by a stalled result. Every entry
// must be loaded before an evaluate reads it. The user must write configuration
// only while no transaction is in flight; the block does not enforce this.
module spin_bond_diagonal_energy
    import sbde_pkg::*;
#(
    parameter int MAX_SITES = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_mode,
    input  logic [SITE_W-1:0]           i_site,
    input  logic [SITE_W-1:0]           i_first_partner,
    input  logic                        i_first_present,
    input  logic [SITE_W-1:0]           i_second_partner,
    input  logic                        i_second_present,
    input  logic                        i_second_negated,
    input  logic [SPIN_W-1:0]           i_spin_state,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [ENERGY_W-1:0]  o_energy
);

    t_cmd        cmd;
    t_status     status;
    t_bond_entry entry;

    assign entry.first_partner  = i_first_partner;
    assign entry.first_present  = i_first_present;
    assign entry.second_partner = i_second_partner;
    assign entry.second_present = i_second_present;
    assign entry.second_negated = i_second_negated;

    sbde_controller u_controller (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_mode   (i_mode),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    sbde_datapath #(
        .MAX_SITES (MAX_SITES)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_site       (i_site),
        .i_entry      (entry),
        .i_spin_state (i_spin_state),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_energy     (o_energy)
    );

endmodule
